// ----- src/pol_pkg.sv -----
// Shared types, sizes and codes for the positional ordered list.
// Used by every module of the block; depends on nothing.
package pol_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 7;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int GRP_SIZE = 32;
  localparam int NGRP     = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

  // request codes
  localparam logic [2:0] FN_INS_HEAD = 3'd0;
  localparam logic [2:0] FN_INS_TAIL = 3'd1;
  localparam logic [2:0] FN_INS_POS  = 3'd2;
  localparam logic [2:0] FN_DEL_HEAD = 3'd3;
  localparam logic [2:0] FN_DEL_TAIL = 3'd4;
  localparam logic [2:0] FN_DEL_POS  = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef struct packed {
    logic [2:0]       func;
    word_t            value;
    logic [POS_W-1:0] position;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       status;
    word_t            removed_value;
    logic [POS_W-1:0] element_count;
    word_t            head_value;
    word_t            tail_value;
  } out_word_t;

  // control broadcast to every cell of the row
  typedef struct packed {
    logic             upd;
    logic             ins;
    logic [IDX_W-1:0] idx;
    word_t            ins_val;
    logic             pick_en;
    logic [IDX_W-1:0] pick_idx;
  } cell_ctl_t;

endpackage

// ----- src/pol_cell.sv -----
// One storage cell of the shifting list row.
// Depends on pol_pkg for the control struct and word type.
module pol_cell
  import pol_pkg::*;
(
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [IDX_W-1:0] cell_idx,
  input  word_t            left_val,
  input  word_t            right_val,
  output word_t            val_o,
  output word_t            tap_o
);

  word_t val_r;
  word_t val_nxt;

  // shift back on insert, shift forward on delete, else hold
  always_comb begin
    val_nxt = val_r;
    if (ctl.upd) begin
      if (ctl.ins) begin
        if (cell_idx == ctl.idx) begin
          val_nxt = ctl.ins_val;
        end else if (cell_idx > ctl.idx) begin
          val_nxt = left_val;
        end
      end else begin
        if (cell_idx >= ctl.idx) begin
          val_nxt = right_val;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  // drive the word onto the gather tree only when picked
  assign val_o = val_r;
  assign tap_o = (ctl.pick_en && (cell_idx == ctl.pick_idx)) ? val_r : '0;

endmodule

// ----- src/pol_gather.sv -----
// Two-level registered OR tree that collects the one picked cell word.
// Depends on pol_pkg for sizes and the word type.
module pol_gather
  import pol_pkg::*;
(
  input  logic  clk,
  input  logic  load,
  input  word_t taps [CAPACITY],
  output word_t result
);

  word_t grp_r   [NGRP];
  word_t grp_nxt [NGRP];

  // first level: fold each group of taps
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GRP_SIZE; k++) begin
        if (g * GRP_SIZE + k < CAPACITY) begin
          grp_nxt[g] = grp_nxt[g] | taps[g * GRP_SIZE + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int g = 0; g < NGRP; g++) begin
        grp_r[g] <= grp_nxt[g];
      end
    end
  end

  // second level: fold the group registers
  always_comb begin
    result = '0;
    for (int g = 0; g < NGRP; g++) begin
      result = result | grp_r[g];
    end
  end

endmodule

// ----- src/positional_ordered_list_top.sv -----
// Top level of the positional ordered list: request decode, sequencer,
// cell row and output register. Depends on pol_pkg, pol_cell, pol_gather.
//
//  channel | direction | word        | handshake
//  in_     | input     | in_word_t   | in_valid / in_stall
//  out_    | output    | out_word_t  | out_valid / out_stall
//
// A word is decoded in its accepting cycle; row shift with removed-word gather,
// tail gather and output load follow in states S_SCAN, S_TAIL and S_FIN, and
// out_valid rises once S_FIN has loaded the output register. in_stall holds until the
// result is taken, so no new word is accepted while one is in flight.
// rst_n empties the list; cell contents are not cleared. out_stall holds the
// result in the output register.
module positional_ordered_list_top
  import pol_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_TAIL = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  typedef struct packed {
    logic             ins;
    logic             del;
    logic [IDX_W-1:0] idx;
    word_t            value;
    logic [1:0]       status;
  } req_t;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  req_t             req_r, req_nxt;
  word_t            removed_r;
  out_word_t        out_r;
  logic             out_valid_r;

  logic             accept;
  logic [CMP_W-1:0] pos_ext, cnt_ext, idx_c;
  logic             pos_one, pos_ok, ins_req, del_req;
  logic [CNT_W-1:0] tail_cnt;

  cell_ctl_t        ctl;
  word_t            cell_val [CAPACITY];
  word_t            cell_tap [CAPACITY];
  word_t            gathered;
  logic             gather_load;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  // decode the request against the current count
  always_comb begin
    pos_ext = CMP_W'(in_data.position);
    cnt_ext = CMP_W'(count_r);
    pos_one = (pos_ext == CMP_W'(1));
    pos_ok  = (pos_ext >= CMP_W'(2)) && (pos_ext <= cnt_ext);
    ins_req = 1'b0;
    del_req = 1'b0;
    idx_c   = '0;
    req_nxt = '0;
    req_nxt.value  = in_data.value;
    req_nxt.status = ST_OK;
    case (in_data.func)
      FN_INS_HEAD: begin
        ins_req = 1'b1;
      end
      FN_INS_TAIL: begin
        ins_req = 1'b1;
        idx_c   = cnt_ext;
      end
      FN_INS_POS: begin
        if (pos_one) begin
          ins_req = 1'b1;
        end else if (pos_ok) begin
          ins_req = 1'b1;
          idx_c   = pos_ext - CMP_W'(1);
        end else begin
          req_nxt.status = ST_INVALID;
        end
      end
      FN_DEL_HEAD: begin
        del_req = 1'b1;
      end
      FN_DEL_TAIL: begin
        del_req = 1'b1;
        idx_c   = cnt_ext - CMP_W'(1);
      end
      FN_DEL_POS: begin
        if (pos_one) begin
          del_req = 1'b1;
        end else if (pos_ok) begin
          del_req = 1'b1;
          idx_c   = pos_ext - CMP_W'(1);
        end else begin
          req_nxt.status = ST_INVALID;
        end
      end
      default: begin
        req_nxt.status = ST_INVALID;
      end
    endcase
    req_nxt.idx = idx_c[IDX_W-1:0];
    if (ins_req) begin
      if (cnt_ext == CMP_W'(CAPACITY)) begin
        req_nxt.status = ST_FULL;
      end else begin
        req_nxt.ins = 1'b1;
      end
    end
    if (del_req) begin
      if (count_r == '0) begin
        req_nxt.status = ST_EMPTY;
      end else begin
        req_nxt.del = 1'b1;
      end
    end
    count_nxt = count_r;
    if (req_nxt.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (req_nxt.del) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // sequence: shift row, gather removed word, gather tail, load result
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_SCAN;
      end
      S_SCAN: state_nxt = S_TAIL;
      S_TAIL: state_nxt = S_FIN;
      S_FIN:  state_nxt = S_OUT;
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
      if (state_r == S_FIN) begin
        out_valid_r <= 1'b1;
      end else if (state_r == S_OUT && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= req_nxt;
    end
    if (state_r == S_TAIL) begin
      removed_r <= gathered;
    end
    if (state_r == S_FIN) begin
      out_r.status        <= req_r.status;
      out_r.removed_value <= removed_r;
      out_r.element_count <= POS_W'(count_r);
      out_r.head_value    <= (count_r != '0) ? cell_val[0] : '0;
      out_r.tail_value    <= gathered;
    end
  end

  // broadcast control to the row
  assign tail_cnt = count_r - CNT_W'(1);
  always_comb begin
    ctl          = '0;
    ctl.ins      = req_r.ins;
    ctl.idx      = req_r.idx;
    ctl.ins_val  = req_r.value;
    gather_load  = 1'b0;
    if (state_r == S_SCAN) begin
      ctl.upd      = req_r.ins || req_r.del;
      ctl.pick_en  = req_r.del;
      ctl.pick_idx = req_r.idx;
      gather_load  = 1'b1;
    end else if (state_r == S_TAIL) begin
      ctl.pick_en  = (count_r != '0);
      ctl.pick_idx = tail_cnt[IDX_W-1:0];
      gather_load  = 1'b1;
    end
  end

  // row of cells, each linked to its neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    word_t left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = cell_val[i];
    end else begin : g_mid_r
      assign right_w = cell_val[i+1];
    end
    pol_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .cell_idx  (IDX_W'(i)),
      .left_val  (left_w),
      .right_val (right_w),
      .val_o     (cell_val[i]),
      .tap_o     (cell_tap[i])
    );
  end

  pol_gather u_gather (
    .clk    (clk),
    .load   (gather_load),
    .taps   (cell_tap),
    .result (gathered)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
